/* src/fbpu_pkg.sv */
`timescale 1ns / 1ps

package fbpu_pkg;

    localparam int FIELD_COUNT = 5;
    localparam int FIELD_W     = 8;
    localparam int COUNT_W     = 16;

    localparam logic [FIELD_W-1:0] ABSENT_BYTE = 8'hFF;
    localparam logic [COUNT_W-1:0] DEFAULT_PATTERN_LEN = 16'd256;

    localparam int FLD_INSTRUMENT = 0;
    localparam int FLD_NOTE       = 1;
    localparam int FLD_EFFECT     = 2;
    localparam int FLD_EFFECT_ARG = 3;
    localparam int FLD_VOLUME     = 4;

    typedef logic [FIELD_W-1:0] t_field_array [FIELD_COUNT];

    typedef struct packed {
        logic [FIELD_W-1:0] instrument;
        logic [FIELD_W-1:0] note_value;
        logic [FIELD_W-1:0] effect_code;
        logic [FIELD_W-1:0] effect_argument;
        logic [FIELD_W-1:0] volume_value;
        logic               last_of_pattern;
    } t_record;

    function automatic logic [FIELD_W-1:0] field_default(input int idx);
        logic [FIELD_W-1:0] val;
        val = '0;
        if (idx == FLD_NOTE || idx == FLD_VOLUME) begin
            val = ABSENT_BYTE;
        end
        return val;
    endfunction

endpackage

/* src/flag_byte_pattern_unpacker.sv */
`timescale 1ns / 1ps

// Unpacks a flag-coded pattern byte stream into five-field command records. The block takes
// one byte per cycle: each byte updates the pending-field mask and field registers in a single
// pass, and a finished record is written into a two-entry output queue in the same cycle.
// Input ready drops only when both queue entries hold results that have not been taken, so
// bytes keep flowing while one record waits at the output. A record appears on the output
// in the cycle after the byte that completes it is accepted when no earlier record is still
// waiting, and otherwise as soon as the records ahead of it have been taken. The pattern
// length register may be written only while the block is idle; a value of zero means 65536
// commands.
module flag_byte_pattern_unpacker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fbpu_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [fbpu_pkg::FIELD_W-1:0]  i_data_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fbpu_pkg::FIELD_W-1:0]  o_instrument,
    output logic [fbpu_pkg::FIELD_W-1:0]  o_note_value,
    output logic [fbpu_pkg::FIELD_W-1:0]  o_effect_code,
    output logic [fbpu_pkg::FIELD_W-1:0]  o_effect_argument,
    output logic [fbpu_pkg::FIELD_W-1:0]  o_volume_value,
    output logic                          o_last_of_pattern
);
    import fbpu_pkg::*;

    logic [COUNT_W-1:0]      r_cmd_limit;
    logic [FIELD_COUNT-1:0]  r_mask;
    logic [FIELD_COUNT-1:0]  n_mask;
    t_field_array            r_fields;
    t_field_array            n_fields;
    logic [COUNT_W-1:0]      r_done;
    logic [COUNT_W-1:0]      n_done;

    t_record                 r_queue [2];
    logic                    r_wr_ptr;
    logic                    r_rd_ptr;
    logic [1:0]              r_count;

    logic                    in_fire;
    logic                    out_fire;
    logic                    emit;
    logic                    push;
    logic [COUNT_W:0]        next_count;
    logic [COUNT_W:0]        limit_ext;
    logic                    is_last;
    logic                    found;
    t_record                 n_record;

    assign o_ready  = (r_count != 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign in_fire  = i_valid && o_ready;
    assign out_fire = o_valid && i_ready;

    always_comb begin
        n_fields = r_fields;
        n_mask   = r_mask;
        found    = 1'b0;
        if (r_mask == '0) begin
            for (int k = 0; k < FIELD_COUNT; k++) begin
                n_fields[k] = field_default(k);
            end
            n_mask = i_data_byte[FIELD_COUNT-1:0];
        end else begin
            for (int k = 0; k < FIELD_COUNT; k++) begin
                if (r_mask[k] && !found) begin
                    n_fields[k] = i_data_byte;
                    n_mask[k]   = 1'b0;
                    found       = 1'b1;
                end
            end
        end
        emit = (n_mask == '0);
    end

    always_comb begin
        next_count = {1'b0, r_done} + {{COUNT_W{1'b0}}, 1'b1};
        limit_ext  = (r_cmd_limit == '0) ? {1'b1, {COUNT_W{1'b0}}} : {1'b0, r_cmd_limit};
        is_last    = (next_count >= limit_ext);
        n_done     = is_last ? '0 : next_count[COUNT_W-1:0];
        n_record.instrument      = n_fields[FLD_INSTRUMENT];
        n_record.note_value      = n_fields[FLD_NOTE];
        n_record.effect_code     = n_fields[FLD_EFFECT];
        n_record.effect_argument = n_fields[FLD_EFFECT_ARG];
        n_record.volume_value    = n_fields[FLD_VOLUME];
        n_record.last_of_pattern = is_last;
    end

    assign push = in_fire && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_limit <= DEFAULT_PATTERN_LEN;
            r_mask      <= '0;
            r_done      <= '0;
            r_wr_ptr    <= 1'b0;
            r_rd_ptr    <= 1'b0;
            r_count     <= 2'd0;
            for (int k = 0; k < FIELD_COUNT; k++) begin
                r_fields[k] <= field_default(k);
            end
        end else begin
            if (i_cfg_we) begin
                r_cmd_limit <= i_cfg_data;
            end
            if (in_fire) begin
                r_mask   <= n_mask;
                r_fields <= n_fields;
                if (emit) begin
                    r_done <= n_done;
                end
            end
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_fire) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !out_fire) begin
                r_count <= r_count + 2'd1;
            end else if (!push && out_fire) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= n_record;
        end
    end

    assign o_instrument      = r_queue[r_rd_ptr].instrument;
    assign o_note_value      = r_queue[r_rd_ptr].note_value;
    assign o_effect_code     = r_queue[r_rd_ptr].effect_code;
    assign o_effect_argument = r_queue[r_rd_ptr].effect_argument;
    assign o_volume_value    = r_queue[r_rd_ptr].volume_value;
    assign o_last_of_pattern = r_queue[r_rd_ptr].last_of_pattern;

    // The queue occupancy never exceeds its two entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("output queue overflow");

    // A completed command without a pop adds exactly one queued record.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !out_fire) |=> (r_count == $past(r_count) + 2'd1))
        else $error("record lost on push");

    // Read and write pointers agree with the occupancy.
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers out of step");

    // The command counter returns to zero after the record that closes a pattern.
    a_done_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && is_last) |=> (r_done == '0))
        else $error("command counter did not wrap");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import fbpu_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [COUNT_W-1:0] i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [FIELD_W-1:0] i_data_byte = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [FIELD_W-1:0] o_instrument;
    logic [FIELD_W-1:0] o_note_value;
    logic [FIELD_W-1:0] o_effect_code;
    logic [FIELD_W-1:0] o_effect_argument;
    logic [FIELD_W-1:0] o_volume_value;
    logic               o_last_of_pattern;

    logic [FIELD_W-1:0]     stream_bytes[$];
    t_record                expected_records[$];
    t_record                next_record;
    logic [FIELD_COUNT-1:0] fields_wanted = '0;
    logic [FIELD_W-1:0]     field_acc [FIELD_COUNT];
    logic [COUNT_W-1:0]     commands_in_pattern = '0;
    logic [COUNT_W-1:0]     pattern_len = DEFAULT_PATTERN_LEN;

    int owed_bytes = 0;
    int bytes_queued = 0;
    int bytes_taken = 0;
    int records_seen = 0;
    int last_seen = 0;
    int lengths_tried = 0;
    int errors = 0;
    int cycle_cnt = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int rx_hold_left = 0;
    bit sender_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit rx_hold_req = 1'b0;
    bit rx_hold_ack = 1'b0;

    logic [FIELD_W-1:0] directed_bytes [24] = '{
        8'h00, 8'hE0,
        8'h1F, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h01, 8'hAA, 8'h02, 8'h55, 8'h04, 8'h0F,
        8'h08, 8'hF0, 8'h10, 8'h3C
    };

    flag_byte_pattern_unpacker dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_data_byte       (i_data_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_instrument      (o_instrument),
        .o_note_value      (o_note_value),
        .o_effect_code     (o_effect_code),
        .o_effect_argument (o_effect_argument),
        .o_volume_value    (o_volume_value),
        .o_last_of_pattern (o_last_of_pattern)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_field_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end
        if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR cycle %0d: %s: got 0x%0h, expected 0x%0h", cycle_cnt, what, got, want);
        errors++;
    endtask

    // Advances the unpacker state by one accepted byte and queues any record it completes.
    task automatic unpack_byte(input logic [FIELD_W-1:0] b);
        logic [COUNT_W:0] count;
        logic [COUNT_W:0] limit;
        t_record          rec;
        if (fields_wanted == '0) begin
            field_acc[FLD_INSTRUMENT] = 8'h00;
            field_acc[FLD_NOTE]       = ABSENT_BYTE;
            field_acc[FLD_EFFECT]     = 8'h00;
            field_acc[FLD_EFFECT_ARG] = 8'h00;
            field_acc[FLD_VOLUME]     = ABSENT_BYTE;
            fields_wanted = b[FIELD_COUNT-1:0];
        end else begin
            for (int i = 0; i < FIELD_COUNT; i++) begin
                if (fields_wanted[i]) begin
                    field_acc[i] = b;
                    fields_wanted[i] = 1'b0;
                    break;
                end
            end
        end
        if (fields_wanted == '0) begin
            count = {1'b0, commands_in_pattern} + 1'b1;
            limit = (pattern_len == '0) ? {1'b1, {COUNT_W{1'b0}}} : {1'b0, pattern_len};
            rec.instrument      = field_acc[FLD_INSTRUMENT];
            rec.note_value      = field_acc[FLD_NOTE];
            rec.effect_code     = field_acc[FLD_EFFECT];
            rec.effect_argument = field_acc[FLD_EFFECT_ARG];
            rec.volume_value    = field_acc[FLD_VOLUME];
            rec.last_of_pattern = (count >= limit);
            commands_in_pattern = rec.last_of_pattern ? '0 : count[COUNT_W-1:0];
            expected_records.push_back(rec);
        end
    endtask

    task automatic queue_byte(input logic [FIELD_W-1:0] b);
        stream_bytes.push_back(b);
        bytes_queued++;
        if (owed_bytes == 0) begin
            owed_bytes = $countones(b[FIELD_COUNT-1:0]);
        end else begin
            owed_bytes--;
        end
    endtask

    // Mostly whole commands with random content; the rest are loose bytes.
    task automatic queue_command();
        int               r;
        logic [FIELD_W-1:0] flag;
        r = $urandom_range(0, 99);
        if (owed_bytes != 0 || r >= 85) begin
            queue_byte(rand_field_byte());
        end else begin
            flag = 8'($urandom_range(0, 255));
            if (r < 10) begin
                flag[FIELD_COUNT-1:0] = '1;
            end else if (r < 18) begin
                flag[FIELD_COUNT-1:0] = '0;
            end
            queue_byte(flag);
            while (owed_bytes != 0) begin
                queue_byte(rand_field_byte());
            end
        end
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        while (stream_bytes.size() != 0 || i_valid) begin
            @(negedge i_clk);
        end
        while (expected_records.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_pattern_len(input logic [COUNT_W-1:0] len);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        pattern_len = len;
        lengths_tried++;
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] len, input int n_bytes,
                             input bit tx_idle, input bit rx_idle, input bit long_hold);
        int target;
        write_pattern_len(len);
        @(negedge i_clk);
        sender_idle_on = tx_idle;
        rx_idle_on     = rx_idle;
        target = bytes_queued + n_bytes;
        while (bytes_queued < target) begin
            queue_command();
        end
        while (owed_bytes != 0) begin
            queue_byte(rand_field_byte());
        end
        if (long_hold) begin
            rx_hold_req = ~rx_hold_req;
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (i_valid && o_ready) begin
                unpack_byte(i_data_byte);
                bytes_taken++;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap != 0) begin
                    i_valid <= 1'b0;
                    tx_gap  <= tx_gap - 1;
                end else if (stream_bytes.size() != 0) begin
                    i_valid     <= 1'b1;
                    i_data_byte <= stream_bytes.pop_front();
                    tx_gap      <= sender_idle_on ? pick_gap() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready      <= 1'b0;
            rx_gap       <= 0;
            rx_hold_left <= 0;
            rx_hold_ack  <= 1'b0;
        end else if (rx_hold_left != 0) begin
            i_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_req != rx_hold_ack) begin
            i_ready      <= 1'b0;
            rx_hold_ack  <= rx_hold_req;
            rx_hold_left <= LONG_HOLD;
        end else if (rx_gap != 0) begin
            i_ready <= 1'b0;
            rx_gap  <= rx_gap - 1;
        end else begin
            i_ready <= 1'b1;
            if (rx_idle_on && o_valid && i_ready) begin
                rx_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            records_seen++;
            if (o_last_of_pattern) begin
                last_seen++;
            end
            if (expected_records.size() == 0) begin
                report_mismatch("record with none expected", records_seen, 0);
            end else begin
                next_record = expected_records.pop_front();
                if (o_instrument !== next_record.instrument) begin
                    report_mismatch("instrument", o_instrument, next_record.instrument);
                end
                if (o_note_value !== next_record.note_value) begin
                    report_mismatch("note_value", o_note_value, next_record.note_value);
                end
                if (o_effect_code !== next_record.effect_code) begin
                    report_mismatch("effect_code", o_effect_code, next_record.effect_code);
                end
                if (o_effect_argument !== next_record.effect_argument) begin
                    report_mismatch("effect_argument", o_effect_argument,
                                    next_record.effect_argument);
                end
                if (o_volume_value !== next_record.volume_value) begin
                    report_mismatch("volume_value", o_volume_value, next_record.volume_value);
                end
                if (o_last_of_pattern !== next_record.last_of_pattern) begin
                    report_mismatch("last_of_pattern", o_last_of_pattern,
                                    next_record.last_of_pattern);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Run stopped by timeout after %0d cycles.", cycle_cnt);
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty flags, ignored high bits, all-field commands at the extremes, and each
        // field on its own, at the reset pattern length.
        foreach (directed_bytes[k]) begin
            queue_byte(directed_bytes[k]);
        end
        wait_idle();

        run_phase(16'd1, 80, 1'b1, 1'b1, 1'b0);
        run_phase(16'd3, 90, 1'b1, 1'b1, 1'b0);
        run_phase(16'd65535, 90, 1'b0, 1'b0, 1'b0);
        run_phase(16'd5, 100, 1'b0, 1'b1, 1'b1);
        run_phase(16'd0, 80, 1'b1, 1'b1, 1'b0);
        run_phase(16'd7, 90, 1'b1, 1'b0, 1'b0);
        // Shrinking the length mid-pattern closes the current pattern early.
        run_phase(16'd2, 80, 1'b1, 1'b1, 1'b0);
        run_phase(16'd16, 90, 1'b0, 1'b1, 1'b0);

        if (expected_records.size() != 0) begin
            report_mismatch("records never produced", 0, expected_records.size());
        end
        $display("Streamed %0d bytes and checked %0d command records, %0d of them closing a pattern.",
                 bytes_taken, records_seen, last_seen);
        $display("Pattern length took %0d written settings, from 1 up to 65535 and zero.",
                 lengths_tried);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
src/fbpu_pkg.sv
src/flag_byte_pattern_unpacker.sv
dv/testbench.sv
